@@ design/pdf_pkg.sv @@
`timescale 1ns / 1ps

package pdf_pkg;

  localparam int PAT_MAX_DEF = 32;
  localparam int WIN_DEPTH   = 32;
  localparam int PAT_BYTES   = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0]               len;  // effective pattern length, 1..window depth
    logic [PAT_BYTES-1:0][7:0]      pat;  // pattern byte 0 in the low bits
  } pdf_cfg_t;

endpackage

@@ design/pdf_cfg.sv @@
`timescale 1ns / 1ps

module pdf_cfg #(
  parameter int WIN = pdf_pkg::WIN_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pdf_pkg::pdf_cfg_t                cfg
);
  import pdf_pkg::*;

  localparam logic [LEN_W-1:0] CAP = LEN_W'(WIN);

  logic [LEN_W-1:0]                plen;
  logic [3:0][CFG_DATA_W-1:0]      words;

  always_ff @(posedge clk) begin
    if (rst) begin
      plen  <= LEN_W'(1);
      words <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LEN:  plen     <= cfg_data[LEN_W-1:0];
        REG_PAT0: words[0] <= cfg_data;
        REG_PAT1: words[1] <= cfg_data;
        REG_PAT2: words[2] <= cfg_data;
        REG_PAT3: words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the window saturates
  always_comb begin
    if (plen == '0)
      cfg.len = LEN_W'(1);
    else if (plen > CAP)
      cfg.len = CAP;
    else
      cfg.len = plen;
    cfg.pat = words;
  end

endmodule

@@ design/pdf_cell.sv @@
`timescale 1ns / 1ps

module pdf_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        shift_en,
  input  logic [7:0]                  d_in,
  input  pdf_pkg::pdf_cfg_t           cfg,
  output logic [7:0]                  q,
  output logic                        ok
);
  import pdf_pkg::*;

  logic [LEN_W-1:0] pidx;
  logic [7:0]       pbyte;

  // cell IDX holds the byte IDX steps back from the newest, so it lines up
  // with pattern byte len-1-IDX
  assign pidx  = cfg.len - LEN_W'(IDX + 1);
  assign pbyte = cfg.pat[pidx[$clog2(PAT_BYTES)-1:0]];
  assign ok    = (LEN_W'(IDX) >= cfg.len) || (d_in == pbyte);

  always_ff @(posedge clk) begin
    if (shift_en) q <= d_in;
  end

endmodule

@@ design/pattern_delete_filter_core.sv @@
`timescale 1ns / 1ps
// A byte completing a non-matching window puts the oldest held byte on m_axis in the next cycle.
// Throughput: one byte per cycle while m_axis_tready holds and no drain runs; the window compare
// is parallel over all cells. A last byte, or a window longer than a newly shortened pattern,
// stalls s_axis while bytes beyond the first leave through the single output register.
// Reset (rst, synchronous): window empty, output register empty, length 1, pattern all zeros.

module pattern_delete_filter_core #(
  parameter int PAT_MAX = pdf_pkg::PAT_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
  input  logic                             s_axis_tlast,   // is_last
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,   // [7:0] out_byte
  output logic                             m_axis_tuser,   // has_byte
  output logic                             m_axis_tlast,   // end_of_stream
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdf_pkg::*;

  localparam int WIN = (PAT_MAX < WIN_DEPTH) ? PAT_MAX : WIN_DEPTH;
  localparam int CW  = $clog2(WIN + 1);
  localparam int IW  = $clog2(WIN);

  pdf_cfg_t         cfg;
  logic [7:0]       cell_q [WIN];
  logic [7:0]       cell_d [WIN];
  logic [WIN-1:0]   cell_ok;

  logic [CW-1:0]    count;
  logic [CW-1:0]    lo;
  logic             drain;
  logic             clr;
  logic             lastp;

  logic             accept;
  logic             can_load;
  logic [CW-1:0]    len_c;
  logic [CW-1:0]    n;
  logic [CW-1:0]    cnt_m1;
  logic             ge;
  logic             match;
  logic [CW-1:0]    lo_a;
  logic             e_zero;
  logic             e_one;
  logic [7:0]       rd_byte;

  assign cfg_ready = 1'b1;

  pdf_cfg #(.WIN(WIN)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign cell_d[j] = s_axis_tdata;
    end else begin : g_link
      assign cell_d[j] = cell_q[j-1];
    end
    pdf_cell #(.IDX(j)) u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (cell_d[j]),
      .cfg      (cfg),
      .q        (cell_q[j]),
      .ok       (cell_ok[j])
    );
  end

  assign can_load      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !drain && can_load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len_c   = CW'(cfg.len);
  assign n       = count + CW'(1);
  assign cnt_m1  = count - CW'(1);
  assign ge      = (n >= len_c);
  assign match   = ge && (&cell_ok);
  // oldest byte sits at index count-1 before the shift, or is the new byte itself
  assign rd_byte = (count == '0) ? s_axis_tdata : cell_q[cnt_m1[IW-1:0]];

  // bytes at window index lo_a and above leave, the rest stay (or drop on a match)
  always_comb begin
    if (s_axis_tlast)
      lo_a = match ? len_c : '0;
    else if (!ge)
      lo_a = n;
    else if (match)
      lo_a = len_c;
    else
      lo_a = len_c - CW'(1);
  end

  assign e_zero = (lo_a == n);
  assign e_one  = (lo_a == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      drain         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        if (e_zero) begin
          count <= match ? '0 : n;
          if (s_axis_tlast) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= '0;
            m_axis_tuser  <= 1'b0;
            m_axis_tlast  <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
          end
        end else begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= rd_byte;
          m_axis_tuser  <= 1'b1;
          m_axis_tlast  <= s_axis_tlast && e_one;
          if (e_one) begin
            count <= match ? '0 : lo_a;
          end else begin
            // count stays: one added, one sent
            drain <= 1'b1;
            lo    <= lo_a;
            clr   <= match;
            lastp <= s_axis_tlast;
          end
        end
      end else if (drain && can_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= rd_byte;
        m_axis_tuser  <= 1'b1;
        m_axis_tlast  <= lastp && (cnt_m1 == lo);
        if (cnt_m1 == lo) begin
          drain <= 1'b0;
          count <= clr ? '0 : cnt_m1;
        end else begin
          count <= cnt_m1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CW'(WIN))
    else $error("window count out of range");

  a_drain_above_lo: assert property (@(posedge clk) disable iff (rst)
    drain |-> count > lo)
    else $error("drain running with nothing left above stop point");

  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("empty beat without end of stream");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tlast |=> drain || count == '0)
    else $error("window not empty after last byte");

  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (rst)
    drain && !$past(drain) |-> $past(accept))
    else $error("drain started without an accepted byte");

endmodule

@@ test/pattern_delete_filter_core_tb.sv @@
`timescale 1ns / 1ps

module pattern_delete_filter_core_tb;
  import pdf_pkg::*;

  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_GOAL   = 210;
  localparam int QUIET_LO    = 90;
  localparam int QUIET_HI    = 150;
  localparam int WIN_CAP     = (PAT_MAX_DEF < WIN_DEPTH) ? PAT_MAX_DEF : WIN_DEPTH;
  localparam int DIR_N       = 23;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } filt_beat_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic                   last;
    logic                   typed;
    filt_beat_t             beat;
  } dir_row_t;

  localparam filt_beat_t NO_BEAT = '0;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] data_byte
  logic                  s_axis_tlast = 1'b0; // is_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] out_byte
  logic                  m_axis_tuser;        // has_byte
  logic                  m_axis_tlast;        // end_of_stream
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic       quiet = 1'b0;
  int         mismatch_cnt = 0;
  int         items_sent = 0;
  int         cycle_cnt = 0;

  // filter model state
  logic [5:0]  cur_len = 6'd1;
  logic [63:0] cur_pat [4] = '{default: '0};
  logic [7:0]  held_bytes [$];
  filt_beat_t  step_beats [$];
  filt_beat_t  exp_beats [$];

  dir_row_t dir_tab [DIR_N];

  pattern_delete_filter_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("pattern_delete_filter_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 37);
  end

  function automatic int eff_len();
    int n;
    n = cur_len;
    if (n < 1) n = 1;
    if (n > WIN_CAP) n = WIN_CAP;
    return n;
  endfunction

  function automatic filt_beat_t pop_held();
    filt_beat_t bt;
    bt.data = held_bytes.pop_front();
    bt.has  = 1'b1;
    bt.eos  = 1'b0;
    return bt;
  endfunction

  // one text byte through the filter; results land in step_beats
  function automatic void filter_step(input logic [7:0] b, input logic last);
    int         n;
    logic       hit;
    filt_beat_t tail;
    n = eff_len();
    step_beats.delete();
    if (held_bytes.size() >= WIN_DEPTH) step_beats.insert(step_beats.size(), pop_held());
    held_bytes.insert(held_bytes.size(), b);
    // a shortened pattern drains the excess oldest bytes first
    while (held_bytes.size() > n) step_beats.insert(step_beats.size(), pop_held());
    if (held_bytes.size() == n) begin
      hit = 1'b1;
      for (int i = 0; i < n; i++)
        if (held_bytes[i] != cur_pat[i >> 3][(i & 7) * 8 +: 8]) hit = 1'b0;
      if (hit) held_bytes.delete();
      else step_beats.insert(step_beats.size(), pop_held());
    end
    if (last) begin
      while (held_bytes.size() > 0) step_beats.insert(step_beats.size(), pop_held());
      if (step_beats.size() == 0) begin
        tail = NO_BEAT;
        tail.eos = 1'b1;
      end else begin
        tail = step_beats.pop_back();
        tail.eos = 1'b1;
      end
      step_beats.insert(step_beats.size(), tail);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    $display("%0t mismatch %s: want %0h got %0h", $time, what, want, got);
    mismatch_cnt++;
  endtask

  always @(posedge clk) begin : out_check
    filt_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (exp_beats.size() == 0) begin
        report_mismatch("beat with nothing pending, out_byte", 8'h00, m_axis_tdata);
      end else begin
        want = exp_beats.pop_front();
        if (m_axis_tdata !== want.data) report_mismatch("out_byte", want.data, m_axis_tdata);
        if (m_axis_tuser !== want.has)
          report_mismatch("has_byte", 8'(want.has), 8'(m_axis_tuser));
        if (m_axis_tlast !== want.eos)
          report_mismatch("end_of_stream", 8'(want.eos), 8'(m_axis_tlast));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input filt_beat_t beat);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    filter_step(b, last);
    if (typed) exp_beats.insert(exp_beats.size(), beat);
    else foreach (step_beats[i]) exp_beats.insert(exp_beats.size(), step_beats[i]);
    items_sent++;
    quiet <= (items_sent >= QUIET_LO) && (items_sent < QUIET_HI);
  endtask

  // caller drops cfg_valid after the last write of a burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LEN:  cur_len = val[LEN_W-1:0];
      REG_PAT0: cur_pat[0] = val;
      REG_PAT1: cur_pat[1] = val;
      REG_PAT2: cur_pat[2] = val;
      REG_PAT3: cur_pat[3] = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int                    start;
    int                    k;
    int                    len_eff;
    int                    ntext;
    int                    nseg;
    int                    r;
    int                    n;
    int                    pmode;
    logic                  close;
    logic [5:0]            len_w;
    logic [7:0]            pat_b [32];
    logic [7:0]            text_q [$];
    logic [CFG_IDX_W-1:0]  reg_ids [5];
    logic [CFG_DATA_W-1:0] reg_vals [5];

    dir_tab = '{
      '{ROW_BYTE, '0, 64'h00, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{ROW_BYTE, '0, 64'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{ROW_BYTE, '0, 64'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      // zero length behaves as length one
      '{ROW_CFG, REG_LEN, 64'd0, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_PAT0, 64'h41, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h41, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h42, 1'b1, 1'b1, '{8'h42, 1'b1, 1'b1}},
      '{ROW_CFG, REG_LEN, 64'd3, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_PAT0, 64'h636261, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h61, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h62, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h61, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h62, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h63, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h78, 1'b1, 1'b0, NO_BEAT},
      // match on the last byte: only the empty end marker
      '{ROW_BYTE, '0, 64'h61, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h62, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h63, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
      // shrink the pattern while two bytes are held
      '{ROW_BYTE, '0, 64'h61, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h62, 1'b0, 1'b0, NO_BEAT},
      '{ROW_CFG, REG_LEN, 64'd1, 1'b0, 1'b0, NO_BEAT},
      '{ROW_BYTE, '0, 64'h63, 1'b1, 1'b0, NO_BEAT}
    };

    reg_ids[0] = REG_LEN;
    reg_ids[1] = REG_PAT0;
    reg_ids[2] = REG_PAT1;
    reg_ids[3] = REG_PAT2;
    reg_ids[4] = REG_PAT3;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int row = 0; row < DIR_N; row++) begin
      if (dir_tab[row].kind == ROW_CFG) begin
        if (row == 0 || dir_tab[row-1].kind != ROW_CFG) wait_idle();
        write_reg(dir_tab[row].idx, dir_tab[row].val);
        if (row == DIR_N - 1 || dir_tab[row+1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        send_byte(dir_tab[row].val[7:0], dir_tab[row].last, dir_tab[row].typed,
                  dir_tab[row].beat);
      end
    end

    while (items_sent < ITEM_GOAL) begin
      wait_idle();
      r = $urandom_range(0, 11);
      case (r)
        0:       len_w = 6'd0;
        1:       len_w = 6'd1;
        2:       len_w = 6'd32;
        3:       len_w = 6'd63;
        4:       len_w = 6'($urandom_range(33, 62));
        default: len_w = 6'($urandom_range(2, 6));
      endcase
      pmode = $urandom_range(0, 5);
      for (int i = 0; i < 32; i++) begin
        case (pmode)
          0: pat_b[i] = 8'h00;
          1: pat_b[i] = 8'hFF;
          2: pat_b[i] = 8'($urandom_range(0, 255));
          default: begin
            case ($urandom_range(0, 4))
              0: pat_b[i] = 8'h00;
              1: pat_b[i] = 8'hFF;
              2: pat_b[i] = 8'h5A;
              3: pat_b[i] = 8'hA5;
              default: pat_b[i] = 8'($urandom_range(0, 255));
            endcase
          end
        endcase
      end
      reg_vals[0] = {58'd0, len_w};
      for (int w = 0; w < 4; w++)
        for (int j = 0; j < 8; j++) reg_vals[w+1][j*8 +: 8] = pat_b[w*8 + j];
      start = $urandom_range(0, 4);
      for (int j = 0; j < 5; j++) begin
        k = (start + j) % 5;
        write_reg(reg_ids[k], reg_vals[k]);
      end
      cfg_valid <= 1'b0;
      len_eff = eff_len();

      ntext = $urandom_range(1, 2);
      for (int t = 0; t < ntext; t++) begin
        text_q.delete();
        nseg = (len_eff > 16) ? $urandom_range(1, 2) : $urandom_range(1, 5);
        for (int s = 0; s < nseg; s++) begin
          r = $urandom_range(0, 9);
          if (r < 5) begin
            for (int i = 0; i < len_eff; i++) text_q.insert(text_q.size(), pat_b[i]);
          end else if (r < 7) begin
            n = $urandom_range(1, len_eff);
            for (int i = 0; i < n; i++) text_q.insert(text_q.size(), pat_b[i]);
          end else if (r < 9) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
              text_q.insert(text_q.size(), pat_b[$urandom_range(0, len_eff - 1)]);
          end else begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
              text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
          end
        end
        // keep the run close to the item goal
        while (text_q.size() > ITEM_GOAL - items_sent) void'(text_q.pop_back());
        // an open text leaves bytes held across the next register writes
        close = (t < ntext - 1) || ($urandom_range(0, 99) < 85);
        for (int i = 0; i < text_q.size(); i++)
          send_byte(text_q[i], close && (i == text_q.size() - 1), 1'b0, NO_BEAT);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("pattern_delete_filter_core regression: pass");
    end else begin
      $display("pattern_delete_filter_core regression: fail");
    end
    $finish;
  end

endmodule
